### src/bcd_pkg.sv
// Shared types, constants and arithmetic helpers for the BC1/BC2/BC3 block decoder.
package bcd_pkg;

    // block_format register codes (code 3 decodes as BC1)
    localparam logic [1:0] FMT_BC1 = 2'd0;
    localparam logic [1:0] FMT_BC2 = 2'd1;
    localparam logic [1:0] FMT_BC3 = 2'd2;

    // Block queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int NUM_PIXELS = 16;
    localparam int PIX_W      = $clog2(NUM_PIXELS);

    // Reciprocal multipliers for the constant divides
    localparam logic [11:0] EXP5_MUL = 12'd2106;  // c*255/31 = (c*2106) >> 8
    localparam logic [12:0] EXP6_MUL = 13'd4145;  // c*255/63 = (c*4145) >> 10
    localparam logic [9:0]  RECIP3   = 10'd683;   // x/3 = (x*683) >> 11, x <= 765
    localparam logic [10:0] RECIP5   = 11'd1639;  // x/5 = (x*1639) >> 13, x <= 1275
    localparam logic [11:0] RECIP7   = 12'd2341;  // x/7 = (x*2341) >> 14, x <= 1785

    // How the alpha of each pixel is formed
    typedef enum logic [1:0] {
        ALPHA_PUNCH    = 2'd0,  // BC1: from palette, index 3 may be transparent
        ALPHA_EXPLICIT = 2'd1,  // BC2: 4-bit nibble * 17
        ALPHA_INTERP   = 2'd2   // BC3: 8-entry interpolated table
    } alpha_mode_t;

    // One classified block as it sits in the queue
    typedef struct packed {
        logic [3:0][7:0] pal_r;
        logic [3:0][7:0] pal_g;
        logic [3:0][7:0] pal_b;
        logic            trans3;   // palette index 3 is transparent black
        alpha_mode_t     amode;
        logic [7:0][7:0] atab;
        logic [31:0]     cidx;
        logic [63:0]     aidx;     // BC2 nibbles, or BC3 3-bit indices from bit 0
    } queue_entry_t;

    // 5-bit channel to 8 bits, truncating c*255/31
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [16:0] p;
        p = 17'(c) * 17'(EXP5_MUL);
        return p[15:8];
    endfunction

    // 6-bit channel to 8 bits, truncating c*255/63
    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [18:0] p;
        p = 19'(c) * 19'(EXP6_MUL);
        return p[17:10];
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'(RECIP3);
        return p[18:11];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'(RECIP5);
        return p[20:13];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'(RECIP7);
        return p[21:14];
    endfunction

endpackage

### src/bc1_bc2_bc3_block_decoder.sv
// Top level of the BC1/BC2/BC3 block decoder: format register, front end, queue, back end.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------------
//  s_       | in        | s_valid / s_ready    | endpoints, colour indices, alpha half
//  m_       | out       | m_valid / m_ready    | RGBA pixel, x, y, last flag
//  cfg_     | in        | cfg_wr_en (no wait)  | cfg_wr_data -> block_format
//
//  The back end emits one pixel per cycle from a 4-bit pixel counter while m_ready does not stall it.
//  After the block transfer, a block passes front stage 1 (loaded at the transfer edge), front stage 2,
//  the queue, pixel select and the output register before its first pixel is valid.
//  Synchronous active-low reset; block_format resets to BC1. No clearing pass.
//  m_ready low while a pixel is held freezes the back end; the two-entry queue lets the front keep taking blocks.
module bc1_bc2_bc3_block_decoder import bcd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_endpoint_first,
    input  logic [15:0] s_endpoint_second,
    input  logic [31:0] s_color_indices,
    input  logic [63:0] s_alpha_block,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha,
    output logic [1:0]  m_pixel_x,
    output logic [1:0]  m_pixel_y,
    output logic        m_last_pixel
);

    logic [1:0]   block_format_reg;
    logic         push, queue_full, pop, q_valid;
    queue_entry_t push_data, q_data;

    // Format register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_format_reg <= FMT_BC1;
        end else if (cfg_wr_en) begin
            block_format_reg <= cfg_wr_data;
        end
    end

    bcd_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .block_format      (block_format_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_endpoint_first  (s_endpoint_first),
        .s_endpoint_second (s_endpoint_second),
        .s_color_indices   (s_color_indices),
        .s_alpha_block     (s_alpha_block),
        .push              (push),
        .push_data         (push_data),
        .queue_full        (queue_full)
    );

    bcd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    bcd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_alpha      (m_alpha),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_last_pixel (m_last_pixel)
    );

endmodule

### src/bcd_front.sv
// Front end: accepts compressed blocks, expands endpoints and builds colour and alpha palettes.
module bcd_front import bcd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [1:0]   block_format,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [15:0]  s_endpoint_first,
    input  logic [15:0]  s_endpoint_second,
    input  logic [31:0]  s_color_indices,
    input  logic [63:0]  s_alpha_block,
    output logic         push,
    output queue_entry_t push_data,
    input  logic         queue_full
);

    // Stage 1: expanded endpoints and classification
    logic              s1_valid_reg;
    logic [2:0][7:0]   s1_ea_reg, s1_eb_reg;
    logic              s1_three_reg;
    alpha_mode_t       s1_amode_reg;
    logic [31:0]       s1_cidx_reg;
    logic [63:0]       s1_aidx_reg;
    logic [7:0]        s1_a0_reg, s1_a1_reg;

    // Stage 2: weighted sums
    logic              s2_valid_reg;
    logic [2:0][7:0]   s2_ea_reg, s2_eb_reg;
    logic [2:0][9:0]   s2_sum2_reg, s2_sum3_reg;
    logic [2:0][9:0]   s2_sum2_next, s2_sum3_next;
    logic [5:0][10:0]  s2_asum_reg, s2_asum_next;
    logic              s2_agt_reg;
    logic              s2_three_reg;
    alpha_mode_t       s2_amode_reg;
    logic [31:0]       s2_cidx_reg;
    logic [63:0]       s2_aidx_reg;
    logic [7:0]        s2_a0_reg, s2_a1_reg;

    logic              s1_free, s2_free, s1_to_s2;
    logic [2:0][7:0]   ea_in, eb_in;
    logic              punch_in;
    alpha_mode_t       amode_in;

    // Flow control: each stage moves when the one after it has room
    assign push     = s2_valid_reg && !queue_full;
    assign s2_free  = !s2_valid_reg || !queue_full;
    assign s1_to_s2 = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_ready  = s1_free;

    // Endpoint expansion and format classification
    always_comb begin
        ea_in[0] = expand5(s_endpoint_first[15:11]);
        ea_in[1] = expand6(s_endpoint_first[10:5]);
        ea_in[2] = expand5(s_endpoint_first[4:0]);
        eb_in[0] = expand5(s_endpoint_second[15:11]);
        eb_in[1] = expand6(s_endpoint_second[10:5]);
        eb_in[2] = expand5(s_endpoint_second[4:0]);
        unique case (block_format)
            FMT_BC2: amode_in = ALPHA_EXPLICIT;
            FMT_BC3: amode_in = ALPHA_INTERP;
            default: amode_in = ALPHA_PUNCH;
        endcase
        punch_in = (amode_in == ALPHA_PUNCH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_free) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s1_free) begin
            s1_ea_reg    <= ea_in;
            s1_eb_reg    <= eb_in;
            s1_three_reg <= punch_in && !(s_endpoint_first > s_endpoint_second);
            s1_amode_reg <= amode_in;
            s1_cidx_reg  <= s_color_indices;
            // BC3 indices start after the two alpha endpoints
            s1_aidx_reg  <= (amode_in == ALPHA_INTERP) ? {16'd0, s_alpha_block[63:16]}
                                                       : s_alpha_block;
            s1_a0_reg    <= s_alpha_block[7:0];
            s1_a1_reg    <= s_alpha_block[15:8];
        end
    end

    // Weighted sums for the interpolated entries
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s2_sum2_next[c] = s1_three_reg
                ? 10'(s1_ea_reg[c]) + 10'(s1_eb_reg[c])
                : {1'b0, s1_ea_reg[c], 1'b0} + 10'(s1_eb_reg[c]);
            s2_sum3_next[c] = 10'(s1_ea_reg[c]) + {1'b0, s1_eb_reg[c], 1'b0};
        end
        for (int k = 1; k <= 6; k++) begin
            if (s1_a0_reg > s1_a1_reg) begin
                s2_asum_next[k-1] = 11'(7 - k) * 11'(s1_a0_reg) + 11'(k) * 11'(s1_a1_reg);
            end else if (k <= 4) begin
                s2_asum_next[k-1] = 11'(5 - k) * 11'(s1_a0_reg) + 11'(k) * 11'(s1_a1_reg);
            end else begin
                s2_asum_next[k-1] = 11'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_free) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_to_s2) begin
            s2_ea_reg    <= s1_ea_reg;
            s2_eb_reg    <= s1_eb_reg;
            s2_sum2_reg  <= s2_sum2_next;
            s2_sum3_reg  <= s2_sum3_next;
            s2_asum_reg  <= s2_asum_next;
            s2_agt_reg   <= s1_a0_reg > s1_a1_reg;
            s2_three_reg <= s1_three_reg;
            s2_amode_reg <= s1_amode_reg;
            s2_cidx_reg  <= s1_cidx_reg;
            s2_aidx_reg  <= s1_aidx_reg;
            s2_a0_reg    <= s1_a0_reg;
            s2_a1_reg    <= s1_a1_reg;
        end
    end

    // Constant divides; the queue registers the result
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [7:0] p0, p1, p2, p3;
            p0 = s2_ea_reg[c];
            p1 = s2_eb_reg[c];
            p2 = s2_three_reg ? s2_sum2_reg[c][8:1] : div3(s2_sum2_reg[c]);
            p3 = s2_three_reg ? 8'd0 : div3(s2_sum3_reg[c]);
            if (c == 0) push_data.pal_r = {p3, p2, p1, p0};
            else if (c == 1) push_data.pal_g = {p3, p2, p1, p0};
            else push_data.pal_b = {p3, p2, p1, p0};
        end
        push_data.atab[0] = s2_a0_reg;
        push_data.atab[1] = s2_a1_reg;
        for (int k = 1; k <= 6; k++) begin
            if (s2_agt_reg) begin
                push_data.atab[k+1] = div7(s2_asum_reg[k-1]);
            end else if (k <= 4) begin
                push_data.atab[k+1] = div5(s2_asum_reg[k-1]);
            end else if (k == 5) begin
                push_data.atab[k+1] = 8'd0;
            end else begin
                push_data.atab[k+1] = 8'd255;
            end
        end
        push_data.trans3 = s2_three_reg;
        push_data.amode  = s2_amode_reg;
        push_data.cidx   = s2_cidx_reg;
        push_data.aidx   = s2_aidx_reg;
    end

    // A block waiting on a full queue holds its sums
    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && queue_full) |=> (s2_valid_reg && $stable(s2_asum_reg)
                                          && $stable(s2_cidx_reg)))
        else $error("stage 2 lost or changed a stalled block");

endmodule

### src/bcd_fifo.sv
// Short queue of classified blocks between the front and back ends.
module bcd_fifo import bcd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  queue_entry_t push_data,
    output logic         full,
    input  logic         pop,
    output queue_entry_t pop_data,
    output logic         not_empty
);

    queue_entry_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full) && !(pop && !not_empty))
        else $error("queue pushed while full or popped while empty");

endmodule

### src/bcd_back.sv
// Back end: walks one block's sixteen pixels and drives the registered pixel output.
module bcd_back import bcd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    input  queue_entry_t q_data,
    output logic         pop,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_red,
    output logic [7:0]   m_green,
    output logic [7:0]   m_blue,
    output logic [7:0]   m_alpha,
    output logic [1:0]   m_pixel_x,
    output logic [1:0]   m_pixel_y,
    output logic         m_last_pixel
);

    queue_entry_t     cur_reg;
    logic             cur_valid_reg;
    logic [PIX_W-1:0] cnt_reg;
    logic [31:0]      cidx_reg;
    logic [63:0]      aidx_reg;

    logic             m_valid_reg;
    logic [7:0]       red_reg, green_reg, blue_reg, alpha_reg;
    logic [PIX_W-1:0] pix_reg;
    logic             last_reg;

    logic             advance, block_done;
    logic [1:0]       ci;
    logic [7:0]       alpha_next;

    assign advance    = cur_valid_reg && (!m_valid_reg || m_ready);
    assign block_done = advance && (cnt_reg == PIX_W'(NUM_PIXELS - 1));
    assign pop        = q_valid && (!cur_valid_reg || block_done);
    assign ci         = cidx_reg[1:0];

    // Alpha of the current pixel
    always_comb begin
        case (cur_reg.amode)
            ALPHA_EXPLICIT: alpha_next = {aidx_reg[3:0], aidx_reg[3:0]};
            ALPHA_INTERP:   alpha_next = cur_reg.atab[aidx_reg[2:0]];
            default:        alpha_next = (cur_reg.trans3 && ci == 2'd3) ? 8'd0 : 8'd255;
        endcase
    end

    // Current block and pixel counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else if (pop) begin
            cur_valid_reg <= 1'b1;
            cnt_reg       <= '0;
        end else if (advance) begin
            cur_valid_reg <= !block_done;
            cnt_reg       <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg  <= q_data;
            cidx_reg <= q_data.cidx;
            aidx_reg <= q_data.aidx;
        end else if (advance) begin
            cidx_reg <= cidx_reg >> 2;
            aidx_reg <= (cur_reg.amode == ALPHA_INTERP) ? aidx_reg >> 3 : aidx_reg >> 4;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            red_reg   <= cur_reg.pal_r[ci];
            green_reg <= cur_reg.pal_g[ci];
            blue_reg  <= cur_reg.pal_b[ci];
            alpha_reg <= alpha_next;
            pix_reg   <= cnt_reg;
            last_reg  <= (cnt_reg == PIX_W'(NUM_PIXELS - 1));
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red        = red_reg;
    assign m_green      = green_reg;
    assign m_blue       = blue_reg;
    assign m_alpha      = alpha_reg;
    assign m_pixel_x    = pix_reg[1:0];
    assign m_pixel_y    = pix_reg[3:2];
    assign m_last_pixel = last_reg;

    a_block_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !block_done) |=> cur_valid_reg)
        else $error("block ended before its sixteenth pixel");

    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (last_reg == (pix_reg == PIX_W'(NUM_PIXELS - 1))))
        else $error("last flag does not match pixel position");

    a_out_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_valid_reg && pix_reg == $past(cnt_reg)))
        else $error("pixel not presented after it was produced");

endmodule
